### rtl/apsc_pkg.sv
// Shared types, register codes and constant tables of the phase sweep controller.
`timescale 1ns / 1ps

package apsc_pkg;

    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 13;
    localparam int LIMIT_W   = 15;
    localparam int GAIN_W    = 16;
    localparam int PHASE_W   = 16;
    localparam int MAXP_W    = 8;
    localparam int OFREQ_W   = 27;
    localparam int MAG_W     = 24;
    localparam int ATAN_N    = 24;
    localparam int IT_W      = 5;
    localparam int Z_W       = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FREQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PH_OFFSET  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS = 3'd7;

    localparam logic [CFG_W-1:0]   RST_START_FREQ = 27'd1000;
    localparam logic [CFG_W-1:0]   RST_STOP_FREQ  = 27'd100000;
    localparam logic [STEP_W-1:0]  RST_MIN_STEP   = 13'd200;
    localparam logic [STEP_W-1:0]  RST_MAX_STEP   = 13'd6400;
    localparam logic [LIMIT_W-1:0] RST_JUMP_LIMIT = 15'd655;
    localparam logic [GAIN_W-1:0]  RST_MAG_GAIN   = 16'd52251;
    localparam logic [PHASE_W-1:0] RST_PH_OFFSET  = 16'hDB0A;
    localparam logic [MAXP_W-1:0]  RST_MAX_POINTS = 8'd100;

    // Quarter turn in Q2.30, used for the pre-rotation into the right half plane.
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] ROUND_Q18   = 34'sd131072;

    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
    };

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_POINT = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_I,
        ST_SQ_Q,
        ST_ROOT,
        ST_CORDIC,
        ST_MAG,
        ST_PHASE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

### rtl/adaptive_phase_sweep_controller.sv
// Top level of the adaptive phase sweep controller.
// A start word is answered from ST_EMIT through the output register; an I word gives none.
// A Q word passes through the squaring, square root, CORDIC, magnitude, phase and decide steps,
// plus the visited-frequency scan of one memory read per stored point, repeated per skip.
// One word is processed at a time; the square root and CORDIC units iterate one step a cycle.
// Synchronous active-low reset restores the register defaults and stops the sweep;
// the point memories are not cleared, only entries written in the current sweep are read.
`timescale 1ns / 1ps

module adaptive_phase_sweep_controller #(
    parameter int POINT_DEPTH       = 128,
    parameter int SAMPLE_BITS       = 24,
    parameter int FREQ_BITS         = 27,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [apsc_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_kind,
    output logic [7:0]                          o_point_index,
    output logic [apsc_pkg::OFREQ_W-1:0]        o_point_freq,
    output logic [apsc_pkg::MAG_W-1:0]          o_magnitude,
    output logic signed [apsc_pkg::PHASE_W-1:0] o_phase,
    output logic [apsc_pkg::OFREQ_W-1:0]        o_next_freq,
    output logic [apsc_pkg::STEP_W-1:0]         o_next_step
);
    import apsc_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int F     = FREQ_BITS;
    localparam int AW    = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
    localparam int CNT_W = $clog2(POINT_DEPTH + 1);
    localparam int CW    = S + 27;
    localparam int PW    = S + GAIN_W + 1;
    localparam logic [F-1:0] FREQ_TOP = {F{1'b1}};

    // Configuration registers
    logic [CFG_W-1:0]   r_start_freq, r_stop_freq;
    logic [STEP_W-1:0]  r_min_step, r_max_step;
    logic [LIMIT_W-1:0] r_jump_limit;
    logic [GAIN_W-1:0]  r_mag_gain;
    logic [PHASE_W-1:0] r_ph_offset;
    logic [MAXP_W-1:0]  r_max_points;

    // Sweep state
    t_state             r_state, n_state;
    logic               r_running, r_expect_q, r_is_start;
    logic [S-1:0]       r_held_i, r_q;
    logic [CNT_W-1:0]   r_count, r_n, r_j;
    logic [F-1:0]       r_cur, r_meas;
    logic [STEP_W-1:0]  r_step;
    logic               r_zero;

    // Arithmetic units
    logic [2*S-1:0]          r_rv, r_rr, r_rb;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [Z_W-1:0]   r_cz;
    logic [IT_W-1:0]         r_it;
    logic [MAG_W-1:0]        r_mag;
    logic signed [PHASE_W-1:0] r_ph;

    // Point memories
    logic signed [PHASE_W-1:0] phase_store [POINT_DEPTH];
    logic [F-1:0]              freq_store  [POINT_DEPTH];
    logic signed [PHASE_W-1:0] r_prev_ph;
    logic [F-1:0]              r_fd;
    logic                      r_pend;

    // Output register
    logic                      r_ov;
    logic [1:0]                r_okind;
    logic [7:0]                r_oidx;
    logic [OFREQ_W-1:0]        r_opf, r_onf;
    logic [MAG_W-1:0]          r_omag;
    logic signed [PHASE_W-1:0] r_oph;
    logic [STEP_W-1:0]         r_ostep;

    // Control strobes
    logic accept, slot_free, emit, scan_hit, scan_last_hit, scan_miss, scan_issue;

    // Combinational helpers
    logic [S-1:0]        abs_i, abs_q, abs_held;
    logic [2*S-1:0]      root_try;
    logic signed [CW-1:0] x0, y0, dx, dy;
    logic signed [Z_W-1:0] atan_z;
    logic [PW-1:0]       mag_full;
    logic [S:0]          mag_shr;
    logic signed [Z_W-1:0] ang_full;
    logic signed [17:0]  ph_wide;
    logic signed [16:0]  ph_diff;
    logic [16:0]         ph_absd;
    logic                jump;
    logic [STEP_W:0]     step_dbl;
    logic [STEP_W-1:0]   step_up, step_new;
    logic [F-1:0]        f_base, f_new, f_skip;
    logic [F:0]          f_sum, f_skip_sum;
    logic [CNT_W-1:0]    cnt_m1;
    logic [AW-1:0]       scan_addr;
    logic                done;

    assign abs_i    = r_held_i[S-1] ? S'(-r_held_i) : r_held_i;
    assign abs_q    = r_q[S-1] ? S'(-r_q) : r_q;
    assign abs_held = abs_i;
    assign root_try = r_rr + r_rb;

    // Inputs scaled by 2^24 for the angle datapath.
    assign x0 = CW'($signed(r_held_i)) <<< 24;
    assign y0 = CW'(i_sample) <<< 24;
    assign dx = r_cy >>> r_it;
    assign dy = r_cx >>> r_it;
    assign atan_z = $signed({2'b00, ATAN_Q30[r_it]});

    assign mag_full = PW'(r_rr[S-1:0]) * PW'(r_mag_gain) + PW'(32768);
    assign mag_shr  = (S+1)'(mag_full >> 16);

    assign ang_full = (r_cz + ROUND_Q18) >>> 18;
    assign ph_wide  = 18'(ang_full) - 18'($signed(r_ph_offset));

    assign ph_diff = 17'(r_ph) - 17'(r_prev_ph);
    assign ph_absd = ph_diff[16] ? 17'(-ph_diff) : ph_diff;
    assign jump    = (r_count != '0) && (ph_absd > 17'(r_jump_limit));

    assign step_dbl = {r_step, 1'b0};
    assign step_up  = (step_dbl > {1'b0, r_max_step}) ? r_max_step : step_dbl[STEP_W-1:0];

    always_comb begin
        f_base   = r_cur;
        step_new = step_up;
        if (jump) begin
            step_new = r_step;
            if (r_step > r_min_step) begin
                f_base   = (r_cur > F'(r_step)) ? r_cur - F'(r_step) : '0;
                step_new = r_min_step;
            end
        end
    end

    assign f_sum      = {1'b0, f_base} + (F+1)'(step_new);
    assign f_new      = f_sum[F] ? FREQ_TOP : f_sum[F-1:0];
    assign f_skip_sum = {1'b0, r_cur} + (F+1)'(r_step);
    assign f_skip     = f_skip_sum[F] ? FREQ_TOP : f_skip_sum[F-1:0];

    assign cnt_m1    = r_count - CNT_W'(1);
    assign scan_addr = r_j[AW-1:0];

    assign scan_hit      = r_pend && (r_fd == r_cur);
    assign scan_last_hit = scan_hit && (r_n == CNT_W'(POINT_DEPTH - 1));
    assign scan_miss     = !scan_hit && !r_pend && (r_j == r_count);
    assign scan_issue    = r_j < r_count;

    assign done = (32'(r_count) >= 32'(r_max_points)) ||
                  (32'(r_count) >= 32'(POINT_DEPTH)) ||
                  (32'(r_cur) > 32'(r_stop_freq));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        n_state = ST_EMIT;
                    end else if (r_running && r_expect_q) begin
                        n_state = ST_SQ_I;
                    end
                end
            end
            ST_SQ_I:   n_state = ST_SQ_Q;
            ST_SQ_Q:   n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_rb[1:0] != 2'b00 && r_rb == (2*S)'(1)) begin
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (r_it == IT_W'(CORDIC_ITERATIONS - 1)) begin
                    n_state = ST_MAG;
                end
            end
            ST_MAG:    n_state = ST_PHASE;
            ST_PHASE:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_last_hit || scan_miss) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs and strobes
    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        accept    = i_valid && (r_state == ST_IDLE);
        slot_free = !r_ov || i_ready;
        emit      = (r_state == ST_EMIT) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_freq <= RST_START_FREQ;
            r_stop_freq  <= RST_STOP_FREQ;
            r_min_step   <= RST_MIN_STEP;
            r_max_step   <= RST_MAX_STEP;
            r_jump_limit <= RST_JUMP_LIMIT;
            r_mag_gain   <= RST_MAG_GAIN;
            r_ph_offset  <= RST_PH_OFFSET;
            r_max_points <= RST_MAX_POINTS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_FREQ: r_start_freq <= i_cfg_data;
                CFG_STOP_FREQ:  r_stop_freq  <= i_cfg_data;
                CFG_MIN_STEP:   r_min_step   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_STEP:   r_max_step   <= i_cfg_data[STEP_W-1:0];
                CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAG_GAIN:   r_mag_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_PH_OFFSET:  r_ph_offset  <= i_cfg_data[PHASE_W-1:0];
                CFG_MAX_POINTS: r_max_points <= i_cfg_data[MAXP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sweep control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_expect_q <= 1'b0;
            r_held_i   <= '0;
            r_count    <= '0;
            r_cur      <= F'(RST_START_FREQ);
            r_step     <= RST_MIN_STEP;
            r_is_start <= 1'b0;
        end else begin
            if (accept) begin
                if (!i_mode) begin
                    r_running  <= 1'b1;
                    r_expect_q <= 1'b0;
                    r_count    <= '0;
                    r_cur      <= F'(r_start_freq);
                    r_step     <= r_min_step;
                    r_is_start <= 1'b1;
                end else if (r_running) begin
                    if (!r_expect_q) begin
                        r_held_i   <= i_sample;
                        r_expect_q <= 1'b1;
                    end else begin
                        r_expect_q <= 1'b0;
                        r_is_start <= 1'b0;
                    end
                end
            end
            if (r_state == ST_DECIDE) begin
                r_cur   <= f_new;
                r_step  <= step_new;
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == ST_SCAN && scan_hit) begin
                r_cur <= f_skip;
            end
            if (emit && !r_is_start && done) begin
                r_running <= 1'b0;
            end
        end
    end

    // Measurement datapath
    always_ff @(posedge i_clk) begin
        if (accept && i_mode && r_running && r_expect_q) begin
            r_q    <= i_sample;
            r_meas <= r_cur;
            r_zero <= (r_held_i == '0) && (i_sample == '0);
            r_it   <= '0;
            if (r_held_i[S-1]) begin
                if (!i_sample[S-1]) begin
                    r_cx <= y0;
                    r_cy <= -x0;
                    r_cz <= HALF_PI_Q30;
                end else begin
                    r_cx <= -y0;
                    r_cy <= x0;
                    r_cz <= -HALF_PI_Q30;
                end
            end else begin
                r_cx <= x0;
                r_cy <= y0;
                r_cz <= '0;
            end
        end
        case (r_state)
            ST_SQ_I: begin
                r_rv <= (2*S)'(abs_held) * (2*S)'(abs_held);
            end
            ST_SQ_Q: begin
                r_rv <= r_rv + (2*S)'(abs_q) * (2*S)'(abs_q);
                r_rr <= '0;
                r_rb <= (2*S)'(1) << (2*S - 2);
            end
            ST_ROOT: begin
                if (r_rv >= root_try) begin
                    r_rv <= r_rv - root_try;
                    r_rr <= (r_rr >> 1) + r_rb;
                end else begin
                    r_rr <= r_rr >> 1;
                end
                r_rb <= r_rb >> 2;
            end
            ST_CORDIC: begin
                if (r_cy < 0) begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_cz <= r_cz - atan_z;
                end else begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_cz <= r_cz + atan_z;
                end
                r_it <= r_it + IT_W'(1);
            end
            ST_MAG: begin
                r_mag <= (mag_shr > (S+1)'({MAG_W{1'b1}})) ? {MAG_W{1'b1}}
                                                            : MAG_W'(mag_shr);
                if (r_zero) begin
                    r_cz <= '0;
                end
            end
            ST_PHASE: begin
                if (ph_wide > 18'sd32767) begin
                    r_ph <= 16'sh7FFF;
                end else if (ph_wide < -18'sd32768) begin
                    r_ph <= 16'sh8000;
                end else begin
                    r_ph <= 16'(ph_wide);
                end
            end
            default: ;
        endcase
    end

    // Point memories: write at the new point, read the previous phase and scan frequencies.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE && 32'(r_count) < 32'(POINT_DEPTH)) begin
            phase_store[r_count[AW-1:0]] <= r_ph;
            freq_store[r_count[AW-1:0]]  <= r_meas;
        end
        r_prev_ph <= phase_store[cnt_m1[AW-1:0]];
        r_fd      <= freq_store[scan_addr];
    end

    // Visited scan: one read issued per cycle, compared in the following cycle; a hit restarts the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_j    <= '0;
            r_n    <= '0;
        end else if (r_state == ST_DECIDE) begin
            r_pend <= 1'b0;
            r_j    <= '0;
            r_n    <= '0;
        end else if (r_state == ST_SCAN) begin
            if (scan_hit) begin
                r_pend <= 1'b0;
                r_j    <= '0;
                r_n    <= r_n + CNT_W'(1);
            end else begin
                r_pend <= scan_issue;
                if (scan_issue) begin
                    r_j <= r_j + CNT_W'(1);
                end
            end
        end else begin
            r_pend <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_onf   <= OFREQ_W'(r_cur);
            r_ostep <= r_step;
            if (r_is_start) begin
                r_okind <= KIND_START;
                r_oidx  <= '0;
                r_opf   <= '0;
                r_omag  <= '0;
                r_oph   <= '0;
            end else begin
                r_okind <= done ? KIND_DONE : KIND_POINT;
                r_oidx  <= 8'(r_count);
                r_opf   <= OFREQ_W'(r_meas);
                r_omag  <= r_mag;
                r_oph   <= r_ph;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_okind;
    assign o_point_index = r_oidx;
    assign o_point_freq  = r_opf;
    assign o_magnitude   = r_omag;
    assign o_phase       = r_oph;
    assign o_next_freq   = r_onf;
    assign o_next_step   = r_ostep;

endmodule

### sim/tb_adaptive_phase_sweep_controller.sv
// Self-checking testbench for the adaptive phase sweep controller with its own sweep predictor.
`timescale 1ns / 1ps

module tb_adaptive_phase_sweep_controller;
    import apsc_pkg::*;

    localparam int DEPTH = 128;
    localparam bit MODE_START = 1'b0;
    localparam bit MODE_CODE = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  index;
        logic [26:0] pfreq;
        logic [23:0] mag;
        logic [15:0] phase;
        logic [26:0] nfreq;
        logic [12:0] nstep;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_mode = 1'b0;
    logic signed [23:0] i_sample = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_point_index;
    logic [26:0] o_point_freq;
    logic [23:0] o_magnitude;
    logic signed [15:0] o_phase;
    logic [26:0] o_next_freq;
    logic [12:0] o_next_step;

    adaptive_phase_sweep_controller uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor configuration and state.
    logic [26:0] cf_start, cf_stop;
    logic [12:0] cf_min, cf_max;
    logic [14:0] cf_limit;
    logic [15:0] cf_gain;
    logic signed [15:0] cf_offset;
    logic [7:0] cf_maxp;
    bit sw_running, sw_quad;
    longint sw_held;
    int unsigned sw_count, sw_freq, sw_step;
    int sw_phases [DEPTH];
    int unsigned sw_freqs [DEPTH];

    t_point expected_points[$];
    int errors = 0;
    int items_sent = 0;
    int points_seen = 0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int vector_angle(longint y, longint x);
        longint z = 0, t, dx, dy;
        if (x == 0 && y == 0) return 0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 1686629713;
            end else begin
                t = x; x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
        end
        return int'((z + 131072) >>> 18);
    endfunction

    function automatic int unsigned step_freq(int unsigned f, int unsigned s);
        longint unsigned r = longint'(f) + s;
        return (r > 134217727) ? 134217727 : int'(r);
    endfunction

    function automatic bit seen_freq(int unsigned f, int unsigned upto);
        for (int i = 0; i < upto && i < DEPTH; i++)
            if (sw_freqs[i] == f) return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_reset();
        cf_start = RST_START_FREQ; cf_stop = RST_STOP_FREQ;
        cf_min = RST_MIN_STEP; cf_max = RST_MAX_STEP;
        cf_limit = RST_JUMP_LIMIT; cf_gain = RST_MAG_GAIN;
        cf_offset = RST_PH_OFFSET; cf_maxp = RST_MAX_POINTS;
        sw_running = 0; sw_quad = 0; sw_held = 0;
        sw_count = 0; sw_freq = 1000; sw_step = 200;
    endtask

    task automatic predict_word(bit mode, logic signed [23:0] code);
        t_point p;
        longint s, iv;
        longint unsigned ui, uq, mag;
        int ph, d;
        int unsigned ix, measured, f;
        bit done;
        if (mode == MODE_START) begin
            sw_running = 1; sw_quad = 0; sw_count = 0;
            sw_freq = 32'(cf_start); sw_step = 32'(cf_min);
            p = '0;
            p.kind = KIND_START;
            p.nfreq = sw_freq[26:0];
            p.nstep = sw_step[12:0];
            expected_points.push_back(p);
            return;
        end
        if (!sw_running) return;
        s = code;
        if (!sw_quad) begin
            sw_held = s;
            sw_quad = 1;
            return;
        end
        sw_quad = 0;
        iv = sw_held;
        ui = iv < 0 ? -iv : iv;
        uq = s < 0 ? -s : s;
        mag = (root_floor(ui * ui + uq * uq) * cf_gain + 32768) >> 16;
        if (mag > 16777215) mag = 16777215;
        ph = vector_angle(s, iv) - int'(cf_offset);
        if (ph > 32767) ph = 32767;
        if (ph < -32768) ph = -32768;
        ix = sw_count;
        measured = sw_freq;
        f = sw_freq;
        d = (ix > 0 && ix <= DEPTH) ? ph - sw_phases[ix-1] : 0;
        if (d < 0) d = -d;
        if (ix > 0 && ix <= DEPTH && d > int'(cf_limit)) begin
            if (sw_step > cf_min) begin
                f = (f > sw_step) ? f - sw_step : 0;
                sw_step = 32'(cf_min);
            end
        end else begin
            sw_step = sw_step * 2;
            if (sw_step > cf_max) sw_step = 32'(cf_max);
        end
        f = step_freq(f, sw_step);
        if (ix < DEPTH) begin
            sw_phases[ix] = ph;
            sw_freqs[ix] = measured;
        end
        ix++;
        sw_count = ix;
        for (int n = 0; n < DEPTH && seen_freq(f, ix); n++)
            f = step_freq(f, sw_step);
        sw_freq = f;
        done = ix >= cf_maxp || ix >= DEPTH || f > cf_stop;
        if (done) sw_running = 0;
        p.kind = done ? KIND_DONE : KIND_POINT;
        p.index = ix[7:0];
        p.pfreq = measured[26:0];
        p.mag = mag[23:0];
        p.phase = ph[15:0];
        p.nfreq = f[26:0];
        p.nstep = sw_step[12:0];
        expected_points.push_back(p);
    endtask

    // Valid stays high into the next word when there is no gap.
    task automatic send_word(bit mode, logic signed [23:0] code);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_sample <= code;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_word(mode, code);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_FREQ: cf_start = val;
            CFG_STOP_FREQ: cf_stop = val;
            CFG_MIN_STEP: cf_min = val[12:0];
            CFG_MAX_STEP: cf_max = val[12:0];
            CFG_JUMP_LIMIT: cf_limit = val[14:0];
            CFG_MAG_GAIN: cf_gain = val[15:0];
            CFG_PH_OFFSET: cf_offset = val[15:0];
            CFG_MAX_POINTS: cf_maxp = val[7:0];
            default: ;
        endcase
    endtask

    // Returns a code that is mostly random but sometimes small or at the extremes.
    function automatic logic signed [23:0] random_code();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1: return 24'(int'($urandom_range(0, 200)) - 100);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [23:0] codes [10] = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0,
            -24'sd1000, 24'sd0, -24'sd1000, -24'sd1, 24'sd5, 24'sh7FFFFF};
        send_word(MODE_CODE, 24'sd77);
        send_word(MODE_START, 24'sd0);
        foreach (codes[i]) send_word(MODE_CODE, codes[i]);
        send_word(MODE_CODE, 24'sd300);
        send_word(MODE_START, 24'sh555555);
        send_word(MODE_CODE, 24'sh2AAAAA);
        send_word(MODE_CODE, -24'sd300);
        drain();
    endtask

    task automatic test_edges();
        // Tiny start, minimum step above maximum step, zero threshold: no back-off can occur.
        write_reg(CFG_START_FREQ, 27'd1);
        write_reg(CFG_STOP_FREQ, 27'h7FFFFFF);
        write_reg(CFG_MIN_STEP, 27'd8191);
        write_reg(CFG_MAX_STEP, 27'd1);
        write_reg(CFG_JUMP_LIMIT, 27'd0);
        write_reg(CFG_MAG_GAIN, 27'hFFFF);
        write_reg(CFG_PH_OFFSET, 27'h8000);
        write_reg(CFG_MAX_POINTS, 27'd128);
        send_word(MODE_START, 24'sd0);
        repeat (60) send_word(MODE_CODE, random_code());
        drain();
        // Near the top the frequency saturates and the skip scan has to give up.
        write_reg(CFG_START_FREQ, 27'h7FFFF00);
        write_reg(CFG_MIN_STEP, 27'd1);
        write_reg(CFG_MAX_STEP, 27'd8191);
        write_reg(CFG_MAG_GAIN, 27'd0);
        write_reg(CFG_PH_OFFSET, 27'h7FFF);
        write_reg(CFG_JUMP_LIMIT, 27'h7FFF);
        send_word(MODE_START, 24'sd0);
        repeat (40) send_word(MODE_CODE, random_code());
        drain();
        write_reg(CFG_MAX_POINTS, 27'd255);
        write_reg(CFG_STOP_FREQ, 27'h7FFFFFF);
        write_reg(CFG_START_FREQ, 27'd5);
        write_reg(CFG_MIN_STEP, 27'd0);
        send_word(MODE_START, 24'sd0);
        repeat (270) send_word(MODE_CODE, random_code());
        drain();
    endtask

    task automatic test_random();
        for (int r = 0; r < 8; r++) begin
            write_reg(CFG_START_FREQ,
                      27'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000)));
            write_reg(CFG_STOP_FREQ,
                      27'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 300000)));
            write_reg(CFG_MIN_STEP, 27'($urandom_range(1, 8191)));
            write_reg(CFG_MAX_STEP, 27'($urandom_range(1, 8191)));
            write_reg(CFG_JUMP_LIMIT, 27'($urandom_range(0, 3000)));
            write_reg(CFG_MAG_GAIN, 27'($urandom));
            write_reg(CFG_PH_OFFSET, 27'($urandom));
            write_reg(CFG_MAX_POINTS, 27'($urandom_range(1, 60)));
            for (int k = 0; k < 190; k++) begin
                if ($urandom_range(0, 40) == 0 || !sw_running) send_word(MODE_START, 24'($urandom));
                else send_word(MODE_CODE, random_code());
            end
            drain();
        end
    endtask

    // Result side: random stalls, each word checked against the oldest prediction.
    initial begin
        t_point got, want;
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got = {o_kind, o_point_index, o_point_freq, o_magnitude, o_phase,
                   o_next_freq, o_next_step};
            points_seen++;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        predict_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_edges();
        test_random();
        if (errors == 0 && expected_points.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### adaptive_phase_sweep_controller.f
rtl/apsc_pkg.sv
rtl/adaptive_phase_sweep_controller.sv
sim/tb_adaptive_phase_sweep_controller.sv
